[hw/rtl/vwcu_pkg.sv]
// Package for the variable-width code unpacker.
// Holds field widths, the minimum code width and the result record.
// No dependencies.
package vwcu_pkg;

  // Field widths of the byte stream and code channels
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WidthW = 5;
  localparam int unsigned CodeW  = 16;

  // Narrowest code the stream uses; smaller widths are taken as this
  localparam logic [WidthW-1:0] MinWidth = 5'd9;

  // One result from the unpack datapath
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code_value;
    logic             end_marker;
  } vwcu_res_t;

endpackage

[hw/rtl/variable_width_code_unpacker_core.sv]
// Variable-width code unpacker, least significant bit first (top level).
// Bytes arrive on the input channel, at most one code leaves per byte
// through the output channel.
//
// Input channel: in_valid_i / in_stall_o carry data_byte_i and code_width_i.
// A transaction completes on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry code_value_o and
// end_marker_o, same rule.
// Configuration: cfg_valid_i / cfg_ready_o write end_code (reset 256);
// ready is always high, write only while the block is idle.
//
// Throughput is one byte per cycle while in_stall_o is low. A code is
// registered before it appears, and leaves from a single result register.
// A two-entry output (result register plus skid register) lets a new byte
// in while a code waits; in_stall_o rises only once both are full, and
// clears once the receiver takes a code. Bytes that complete no code
// produce no output transaction.
// Reset empties the bit buffer and both output entries and restores the
// end code; the block is ready as soon as reset is released.
module variable_width_code_unpacker_core
  import vwcu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte stream
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [WidthW-1:0] code_width_i,
  // code stream
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CodeW-1:0]  code_value_o,
  output logic              end_marker_o,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CodeW-1:0]  cfg_end_code_i
);

  localparam logic [CodeW-1:0] EndCodeRst = 16'd256;

  logic [CodeW-1:0] end_code_q;
  vwcu_res_t        res;
  logic             in_fire;
  logic             out_fire;
  logic             new_res;

  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] out_code_q, out_code_d;
  logic             out_end_q, out_end_d;
  logic             skid_valid_q, skid_valid_d;
  logic [CodeW-1:0] skid_code_q, skid_code_d;
  logic             skid_end_q, skid_end_d;

  // End code register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_code_q <= EndCodeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      end_code_q <= cfg_end_code_i;
    end
  end

  // Handshake
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  vwcu_unpack #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_fire),
    .data_byte_i  (data_byte_i),
    .code_width_i (code_width_i),
    .end_code_i   (end_code_q),
    .res_o        (res)
  );

  assign new_res = in_fire && res.emit;

  // Result register with skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_code_d   = out_code_q;
    out_end_d    = out_end_q;
    skid_valid_d = skid_valid_q;
    skid_code_d  = skid_code_q;
    skid_end_d   = skid_end_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_code_d   = skid_code_q;
        out_end_d    = skid_end_q;
        skid_valid_d = 1'b0;
      end else if (new_res) begin
        out_valid_d = 1'b1;
        out_code_d  = res.code_value;
        out_end_d   = res.end_marker;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (new_res) begin
      skid_valid_d = 1'b1;
      skid_code_d  = res.code_value;
      skid_end_d   = res.end_marker;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_code_q  <= out_code_d;
    out_end_q   <= out_end_d;
    skid_code_q <= skid_code_d;
    skid_end_q  <= skid_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_value_o = out_code_q;
  assign end_marker_o = out_end_q;

endmodule

[hw/rtl/vwcu_unpack.sv]
// Bit buffer and code extraction for the variable-width code unpacker.
// Depends on vwcu_pkg; instantiated by variable_width_code_unpacker_core.
module vwcu_unpack
  import vwcu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [WidthW-1:0] code_width_i,
  input  logic [CodeW-1:0]  end_code_i,
  output vwcu_res_t         res_o
);

  localparam int unsigned BufW = MAX_WIDTH + 7;
  localparam int unsigned CntW = $clog2(MAX_WIDTH + 8);
  localparam logic [WidthW-1:0] MaxWidth = WidthW'(MAX_WIDTH);

  logic [BufW-1:0]   buf_q, buf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [WidthW-1:0] width;
  logic [BufW-1:0]   merged;
  logic [CntW-1:0]   sum;
  logic [BufW-1:0]   mask;
  logic [BufW-1:0]   code_full;
  logic              emit;
  logic              is_end;

  // Clamp the requested width into the supported range
  always_comb begin
    if (code_width_i < MinWidth) begin
      width = MinWidth;
    end else if (code_width_i > MaxWidth) begin
      width = MaxWidth;
    end else begin
      width = code_width_i;
    end
  end

  // Append the byte above the leftover bits and pick off one code
  always_comb begin
    merged    = buf_q | (BufW'(data_byte_i) << cnt_q);
    sum       = cnt_q + CntW'(ByteW);
    emit      = ({1'b0, sum} >= {1'b0, CntW'(width)});
    mask      = ~({BufW{1'b1}} << width);
    code_full = merged & mask;
    is_end    = emit && (code_full == BufW'(end_code_i));
  end

  // Next buffer state: end code flushes all leftover bits
  always_comb begin
    if (is_end) begin
      buf_d = '0;
      cnt_d = '0;
    end else if (emit) begin
      buf_d = merged >> width;
      cnt_d = sum - CntW'(width);
    end else begin
      buf_d = merged;
      cnt_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

  assign res_o.emit       = emit;
  assign res_o.code_value = code_full[CodeW-1:0];
  assign res_o.end_marker = is_end;

endmodule
